FILE: hw/rtl/rtfc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtfc_pkg
// shared constants and types for the region table fault checker
// ----------------------------------------------------------------------------
package rtfc_pkg;

	localparam int MAX_REGIONS = 16;
	localparam int PAGE_SHIFT  = 12;
	localparam int IDX_W       = $clog2(MAX_REGIONS);
	localparam int CNT_W       = $clog2(MAX_REGIONS + 1);

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_LOOKUP = 2'd1;
	localparam logic [1:0] OP_FAULT  = 2'd2;
	localparam logic [1:0] OP_CLEAR  = 2'd3;

	localparam logic [2:0] FLAG_READ  = 3'd1;
	localparam logic [2:0] FLAG_WRITE = 3'd2;
	localparam logic [2:0] FLAG_EXEC  = 3'd4;
	localparam logic [2:0] PERM_USER  = 3'd4;
	localparam logic [2:0] PERM_WRITE = 3'd2;

	localparam logic [2:0] ST_OK           = 3'd0;
	localparam logic [2:0] ST_NO_REGION    = 3'd1;
	localparam logic [2:0] ST_WRITE_DENIED = 3'd2;
	localparam logic [2:0] ST_READ_PRESENT = 3'd3;
	localparam logic [2:0] ST_READ_DENIED  = 3'd4;
	localparam logic [2:0] ST_FULL         = 3'd5;
	localparam logic [2:0] ST_BAD_INSERT   = 3'd6;

	typedef struct packed {
		logic [31:0] start;
		logic [31:0] stop;
		logic [2:0]  flags;
	} region_t;

endpackage

FILE: hw/rtl/rtfc_region_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtfc_region_ram
// region entry memory, one write and one registered read port
// ----------------------------------------------------------------------------
module rtfc_region_ram (
	input  logic                        clk,
	input  logic                        we,
	input  logic [rtfc_pkg::IDX_W-1:0]  waddr,
	input  rtfc_pkg::region_t           wdata,
	input  logic [rtfc_pkg::IDX_W-1:0]  raddr,
	output rtfc_pkg::region_t           rdata
);

	rtfc_pkg::region_t mem [rtfc_pkg::MAX_REGIONS];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

FILE: hw/rtl/region_table_fault_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// region_table_fault_checker
// sorted region table with lookup, insert and fault classification
// ----------------------------------------------------------------------------
// one transaction at a time; the entry ram has one read port with a registered read
// lookup: reads the last-hit entry first when it is valid and inside the table, else scans
//   entries from zero (an empty table misses at once); a last-hit read that misses falls back to a full scan
// insert: scans to the position, shifts later entries up (read, write), writes the new entry
// clear empties the table; result held in an output register, next input the cycle after it is taken
// reset: table empty, last hit invalid, fault counter zero; ram not cleared
module region_table_fault_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  operation,
	input  logic [31:0] addr,
	input  logic [31:0] region_end_in,
	input  logic [2:0]  region_flags_in,
	input  logic [1:0]  fault_code,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        found,
	output logic [31:0] region_start_out,
	output logic [31:0] region_end_out,
	output logic [2:0]  region_flags_out,
	output logic [2:0]  status,
	output logic [2:0]  entry_perm,
	output logic [31:0] page_addr,
	output logic [31:0] fault_count
);

	localparam int IW = rtfc_pkg::IDX_W;
	localparam int CW = rtfc_pkg::CNT_W;

	typedef enum logic [2:0] {
		S_IDLE, S_HIT_RD, S_SCAN_RD, S_SCAN_CHK, S_INS_CHK, S_SHIFT_RD, S_SHIFT_WR, S_DONE
	} state_t;

	state_t state_q;

	// captured transaction
	logic [1:0]  op_q;
	logic [31:0] a_q, e_q;
	logic [2:0]  fl_q;
	logic [1:0]  ec_q;

	logic [CW-1:0] count_q;
	logic          lh_valid_q;
	logic [IW-1:0] lh_index_q;
	logic [31:0]   fault_q;
	logic [CW-1:0] ptr_q;     // scan index or shift source+1
	logic [CW-1:0] pos_q;     // insert position
	logic          prev_bad_q; // previous entry end > start

	// marks that the entry under check came from the last-hit read
	logic lh_hit_path_q;
	logic lh_hit_path;

	// ram port
	logic              we;
	logic [IW-1:0]     waddr, raddr;
	rtfc_pkg::region_t wdata, rdata;

	rtfc_region_ram u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	logic holds;
	assign holds = (rdata.start <= a_q) && (a_q < rdata.stop);

	// fault classification of a hit entry
	function automatic logic [2:0] classify(input logic [1:0] ec, input logic [2:0] rf);
		logic [2:0] st;
		st = rtfc_pkg::ST_OK;
		if (ec[1]) begin
			if ((rf & rtfc_pkg::FLAG_WRITE) == 3'd0) st = rtfc_pkg::ST_WRITE_DENIED;
		end else if (ec[0]) begin
			st = rtfc_pkg::ST_READ_PRESENT;
		end else if ((rf & (rtfc_pkg::FLAG_READ | rtfc_pkg::FLAG_EXEC)) == 3'd0) begin
			st = rtfc_pkg::ST_READ_DENIED;
		end
		return st;
	endfunction

	assign in_ready = (state_q == S_IDLE);

	// ram address and write control
	always_comb begin
		we    = 1'b0;
		waddr = ptr_q[IW-1:0];
		wdata = rdata;
		raddr = ptr_q[IW-1:0];
		if (state_q == S_HIT_RD) raddr = lh_index_q;
		if (state_q == S_SHIFT_RD) raddr = IW'(ptr_q - CW'(1));
		if (state_q == S_SHIFT_WR) begin
			we = 1'b1;
			if (ptr_q == pos_q) begin
				wdata = '{start: a_q, stop: e_q, flags: fl_q};
				waddr = pos_q[IW-1:0];
			end
		end
	end

	// finish a lookup or fault check with an entry or a miss
	task automatic finish_lookup(input logic hit, input rtfc_pkg::region_t r);
		logic [2:0]  st;
		logic [2:0]  perm;
		logic [31:0] pa;
		st   = hit ? rtfc_pkg::ST_OK : rtfc_pkg::ST_NO_REGION;
		perm = 3'd0;
		pa   = 32'd0;
		if (op_q == rtfc_pkg::OP_FAULT) begin
			pa = a_q & (32'hFFFF_FFFF << rtfc_pkg::PAGE_SHIFT);
			if (hit) begin
				st = classify(ec_q, r.flags);
				if (st == rtfc_pkg::ST_OK)
					perm = rtfc_pkg::PERM_USER |
						(((r.flags & rtfc_pkg::FLAG_WRITE) != 3'd0) ?
							rtfc_pkg::PERM_WRITE : 3'd0);
			end
		end
		found            <= hit;
		region_start_out <= hit ? r.start : 32'd0;
		region_end_out   <= hit ? r.stop : 32'd0;
		region_flags_out <= hit ? r.flags : 3'd0;
		entry_perm       <= perm;
		page_addr        <= pa;
		status           <= st;
	endtask

	task automatic finish_insert(input logic [2:0] st);
		found            <= 1'b0;
		region_start_out <= 32'd0;
		region_end_out   <= 32'd0;
		region_flags_out <= 3'd0;
		entry_perm       <= 3'd0;
		page_addr        <= 32'd0;
		status           <= st;
	endtask

	// report an insert error and hold the table
	task automatic ins_fail(input logic [2:0] st);
		finish_insert(st);
		fault_count <= fault_q;
		out_valid <= 1'b1;
		state_q <= S_DONE;
	endtask

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			out_valid  <= 1'b0;
			count_q    <= '0;
			lh_valid_q <= 1'b0;
			lh_index_q <= '0;
			fault_q    <= '0;
			fault_count <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q <= operation; a_q <= addr; e_q <= region_end_in;
						fl_q <= region_flags_in; ec_q <= fault_code;
						prev_bad_q <= 1'b0;
						unique case (operation)
							rtfc_pkg::OP_CLEAR: begin
								count_q <= '0; lh_valid_q <= 1'b0;
								finish_insert(rtfc_pkg::ST_OK);
								fault_count <= fault_q;
								out_valid <= 1'b1;
								state_q <= S_DONE;
							end
							rtfc_pkg::OP_INSERT: begin
								if (addr >= region_end_in) begin
									finish_insert(rtfc_pkg::ST_BAD_INSERT);
									fault_count <= fault_q;
									out_valid <= 1'b1;
									state_q <= S_DONE;
								end else if (count_q == '0) begin
									pos_q <= '0;
									finish_insert(rtfc_pkg::ST_OK);
									state_q <= S_SHIFT_WR;
									ptr_q <= '0;
								end else begin
									ptr_q <= '0;
									state_q <= S_SCAN_RD;
								end
							end
							default: begin
								if (operation == rtfc_pkg::OP_FAULT) fault_q <= fault_q + 32'd1;
								// an empty table also starts at zero and misses right away
								ptr_q <= '0;
								if (lh_valid_q && (CW'(lh_index_q) < count_q))
									state_q <= S_HIT_RD;
								else if (count_q == '0)
									state_q <= S_SCAN_CHK;
								else state_q <= S_SCAN_RD;
							end
						endcase
					end
				end
				S_HIT_RD: state_q <= S_SCAN_CHK; // flagged by lh_hit_path
				S_SCAN_RD: state_q <= (op_q == rtfc_pkg::OP_INSERT) ? S_INS_CHK : S_SCAN_CHK;
				S_SCAN_CHK: begin
					fault_count <= fault_q;
					if (ptr_q >= count_q) begin
						finish_lookup(1'b0, rdata);
						out_valid <= 1'b1; state_q <= S_DONE;
					end else if (holds) begin
						finish_lookup(1'b1, rdata);
						if (!lh_hit_path) begin
							lh_valid_q <= 1'b1; lh_index_q <= ptr_q[IW-1:0];
						end
						out_valid <= 1'b1; state_q <= S_DONE;
					end else if (lh_hit_path) begin
						// last hit missed: full scan from zero
						ptr_q <= '0; state_q <= S_SCAN_RD;
					end else if (ptr_q + CW'(1) >= count_q) begin
						finish_lookup(1'b0, rdata);
						out_valid <= 1'b1; state_q <= S_DONE;
					end else begin
						ptr_q <= ptr_q + CW'(1); state_q <= S_SCAN_RD;
					end
				end
				S_INS_CHK: begin
					// rdata is entry ptr_q, ptr_q < count_q
					if (rdata.start <= a_q) begin
						prev_bad_q <= rdata.stop > a_q;
						if (ptr_q + CW'(1) < count_q) begin
							ptr_q <= ptr_q + CW'(1); state_q <= S_SCAN_RD;
						end else begin
							pos_q <= count_q;
							if (rdata.stop > a_q) ins_fail(rtfc_pkg::ST_BAD_INSERT);
							else if (count_q >= CW'(rtfc_pkg::MAX_REGIONS))
								ins_fail(rtfc_pkg::ST_FULL);
							else begin
								ptr_q <= count_q; state_q <= S_SHIFT_WR;
								finish_insert(rtfc_pkg::ST_OK);
							end
						end
					end else begin
						pos_q <= ptr_q;
						if (prev_bad_q || e_q > rdata.start) ins_fail(rtfc_pkg::ST_BAD_INSERT);
						else if (count_q >= CW'(rtfc_pkg::MAX_REGIONS))
							ins_fail(rtfc_pkg::ST_FULL);
						else begin
							ptr_q <= count_q; state_q <= S_SHIFT_RD;
							finish_insert(rtfc_pkg::ST_OK);
						end
					end
				end
				S_SHIFT_RD: state_q <= S_SHIFT_WR;
				S_SHIFT_WR: begin
					// writes entry ptr_q from ptr_q-1, or the new region at pos
					if (ptr_q == pos_q) begin
						count_q <= count_q + CW'(1);
						if (lh_valid_q && CW'(lh_index_q) >= pos_q)
							lh_index_q <= lh_index_q + IW'(1);
						fault_count <= fault_q;
						out_valid <= 1'b1; state_q <= S_DONE;
					end else begin
						ptr_q <= ptr_q - CW'(1);
						state_q <= ((ptr_q - CW'(1)) == pos_q) ? S_SHIFT_WR : S_SHIFT_RD;
					end
				end
				S_DONE: begin
					if (out_ready) begin
						out_valid <= 1'b0; state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign lh_hit_path = lh_hit_path_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) lh_hit_path_q <= 1'b0;
		else if (state_q == S_HIT_RD) lh_hit_path_q <= 1'b1;
		else if (state_q == S_SCAN_RD || state_q == S_IDLE) lh_hit_path_q <= 1'b0;
	end

	// assertions
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(rtfc_pkg::MAX_REGIONS)) else $error("region count overflow");
	a_ready_out: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("input taken while result pending");
	a_fault_inc: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && operation == rtfc_pkg::OP_FAULT) |=>
			fault_q == $past(fault_q) + 32'd1)
		else $error("fault counter not advanced");

endmodule
